>>> src/dwp_pkg.sv
// Shared types and constants for the draw-without-replacement pool.
package dwp_pkg;

  localparam int POOL_ENTRIES_DEF = 1024;
  localparam int IDX_SPAN         = 1024;
  localparam int IDX_W            = 10;
  localparam int CNT_W            = 11;
  localparam int WORD_W           = 32;
  localparam int BIT_W            = 5;

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_DISABLE = 2'd1,
    CMD_UNDO    = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_NOT_LOAD  = 3'd2,
    ST_RANK_BIG  = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SELECT,
    S_DISABLE,
    S_POP,
    S_RESTORE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] picked;
    status_e          status;
    logic [CNT_W-1:0] remaining;
    logic             exhausted;
  } res_t;

endpackage

>>> src/draw_without_replacement_pool_unit.sv
// Top level: stream ports, size register, result register, memories and sequencer.
// From input beat to result beat: reset and commands rejected at the check go straight to done;
// disable takes one disable step (also when the entry is already disabled), undo a pop and a
// restore step, draw a one-word-per-cycle mark scan up to the rank's word and 5 select steps.
// One command at a time; the next beat is taken once the result enters the output register.
// Reset clears size, count and stack depth, marks the pool exhausted and invalidates mark rows.
module draw_without_replacement_pool_unit import dwp_pkg::*; #(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // rank[9:0], entry_index[19:10], zero pad
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // picked_index[9:0], remaining[20:10], zero pad
  output logic [3:0]  m_axis_tuser   // status[2:0], exhausted[3]
);

  localparam int EFF_ENTRIES = (POOL_ENTRIES < IDX_SPAN) ? POOL_ENTRIES : IDX_SPAN;
  localparam int NWORDS      = (EFF_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int WAW         = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SAW         = $clog2(EFF_ENTRIES);

  logic [CNT_W-1:0]  pool_size_q;
  res_t              res, out_q;
  logic              res_valid, res_ready, out_valid_q;
  logic              mk_clear, mk_rd_en, mk_wr_en;
  logic [WAW-1:0]    mk_rd_addr, mk_wr_addr;
  logic [WORD_W-1:0] mk_rd_data, mk_wr_data;
  logic              st_wr_en, st_rd_en;
  logic [SAW-1:0]    st_wr_addr, st_rd_addr;
  logic [IDX_W-1:0]  st_wr_data, st_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) pool_size_q <= cfg_wdata_i;
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign res_ready     = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.remaining, out_q.picked};
  assign m_axis_tuser  = {out_q.exhausted, out_q.status};

  dwp_seq #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .EFF_ENTRIES  (EFF_ENTRIES),
    .NWORDS       (NWORDS),
    .WAW          (WAW),
    .SAW          (SAW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .cmd_i        (cmd_e'(s_axis_tuser)),
    .rank_i       (s_axis_tdata[9:0]),
    .idx_i        (s_axis_tdata[19:10]),
    .pool_size_i  (pool_size_q),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .mk_clear_o   (mk_clear),
    .mk_rd_en_o   (mk_rd_en),
    .mk_rd_addr_o (mk_rd_addr),
    .mk_rd_data_i (mk_rd_data),
    .mk_wr_en_o   (mk_wr_en),
    .mk_wr_addr_o (mk_wr_addr),
    .mk_wr_data_o (mk_wr_data),
    .st_wr_en_o   (st_wr_en),
    .st_wr_addr_o (st_wr_addr),
    .st_wr_data_o (st_wr_data),
    .st_rd_en_o   (st_rd_en),
    .st_rd_addr_o (st_rd_addr),
    .st_rd_data_i (st_rd_data)
  );

  dwp_mark_mem #(
    .NWORDS (NWORDS),
    .AW     (WAW)
  ) u_mark_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (mk_clear),
    .rd_en_i   (mk_rd_en),
    .rd_addr_i (mk_rd_addr),
    .rd_data_o (mk_rd_data),
    .wr_en_i   (mk_wr_en),
    .wr_addr_i (mk_wr_addr),
    .wr_data_i (mk_wr_data)
  );

  dwp_stack_mem #(
    .DEPTH (EFF_ENTRIES),
    .AW    (SAW)
  ) u_stack_mem (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (st_wr_addr),
    .wr_data_i (st_wr_data),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

endmodule

>>> src/dwp_mark_mem.sv
// Available-mark memory, one word of marks per row, with per-row valid bits.
module dwp_mark_mem import dwp_pkg::*; #(
  parameter int NWORDS = 32,
  parameter int AW     = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i
);

  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] vld_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clear_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // unwritten rows read as all marks set
  assign rd_data_o = rvld_q ? rdata_q : '1;

endmodule

>>> src/dwp_stack_mem.sv
// Undo stack memory of disabled entry indexes.
module dwp_stack_mem import dwp_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [IDX_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [IDX_W-1:0] rd_data_o
);

  logic [IDX_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule

>>> src/dwp_seq.sv
// Command sequencer: checks, rank scan, read-modify-write of marks and stack.
module dwp_seq import dwp_pkg::*; #(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int EFF_ENTRIES  = (POOL_ENTRIES < IDX_SPAN) ? POOL_ENTRIES : IDX_SPAN,
  parameter int NWORDS       = (EFF_ENTRIES + WORD_W - 1) / WORD_W,
  parameter int WAW          = (NWORDS > 1) ? $clog2(NWORDS) : 1,
  parameter int SAW          = $clog2(EFF_ENTRIES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  cmd_e              cmd_i,
  input  logic [IDX_W-1:0]  rank_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [CNT_W-1:0]  pool_size_i,
  output res_t              res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              mk_clear_o,
  output logic              mk_rd_en_o,
  output logic [WAW-1:0]    mk_rd_addr_o,
  input  logic [WORD_W-1:0] mk_rd_data_i,
  output logic              mk_wr_en_o,
  output logic [WAW-1:0]    mk_wr_addr_o,
  output logic [WORD_W-1:0] mk_wr_data_o,
  output logic              st_wr_en_o,
  output logic [SAW-1:0]    st_wr_addr_o,
  output logic [IDX_W-1:0]  st_wr_data_o,
  output logic              st_rd_en_o,
  output logic [SAW-1:0]    st_rd_addr_o,
  input  logic [IDX_W-1:0]  st_rd_data_i
);

  function automatic logic [5:0] popcnt32(input logic [WORD_W-1:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + 6'(v[i]);
    end
    return c;
  endfunction

  state_e           state_q, state_d;
  cmd_e             cmd_q;
  logic [IDX_W-1:0] rank_q, idx_q, e_q, k_q;
  logic [CNT_W-1:0] depth_q, count_q;
  logic             nr_q;
  logic [WAW-1:0]   w_q;
  logic [WORD_W-1:0] word_q;
  logic [2:0]       lvl_q;
  logic [BIT_W-1:0] base_q;
  res_t             res_q;

  logic [CNT_W-1:0]  size;
  logic              size_zero;
  logic [CNT_W-1:0]  depth_dec, count_dec, count_inc;
  logic [WORD_W-1:0] scan_mask, masked;
  logic [5:0]        pc_word, pc_lo;
  logic [BIT_W-1:0]  half, base_next;
  logic [WORD_W-1:0] lo_mask;
  logic              draw_rej, dis_rej, dis_bit, rst_bit_sel;
  logic              k_in_word, k_in_lo, last_word;
  logic [5:0]        w_ext;

  assign size      = (32'(pool_size_i) > EFF_ENTRIES) ? CNT_W'(EFF_ENTRIES) : pool_size_i;
  assign size_zero = (size == '0);
  assign depth_dec = depth_q - CNT_W'(1);
  assign count_dec = count_q - CNT_W'(1);
  assign count_inc = (32'(count_q) < POOL_ENTRIES) ? count_q + CNT_W'(1) : count_q;

  assign w_ext = 6'(w_q);
  always_comb begin
    if (w_ext < size[CNT_W-1:BIT_W]) begin
      scan_mask = '1;
    end else if (w_ext == size[CNT_W-1:BIT_W]) begin
      scan_mask = (WORD_W'(1) << size[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      scan_mask = '0;
    end
  end

  assign masked    = mk_rd_data_i & scan_mask;
  assign pc_word   = popcnt32(masked);
  assign k_in_word = (k_q < IDX_W'(pc_word));
  assign last_word = (w_q == WAW'(NWORDS - 1));

  assign half      = 5'd16 >> lvl_q;
  assign lo_mask   = (WORD_W'(1) << half) - WORD_W'(1);
  assign pc_lo     = popcnt32(word_q & lo_mask);
  assign k_in_lo   = (k_q < IDX_W'(pc_lo));
  assign base_next = k_in_lo ? base_q : base_q + half;

  assign draw_rej = size_zero || nr_q || ({1'b0, rank_q} >= count_q);
  assign dis_rej  = size_zero || ({1'b0, idx_q} >= size) || (count_q == '0) ||
                    (32'(depth_q) >= EFF_ENTRIES);
  assign dis_bit     = mk_rd_data_i[idx_q[BIT_W-1:0]];
  assign rst_bit_sel = (cmd_q == CMD_UNDO);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        unique case (cmd_q)
          CMD_DRAW:    state_d = draw_rej ? S_DONE : S_SCAN;
          CMD_DISABLE: state_d = dis_rej ? S_DONE : S_DISABLE;
          CMD_UNDO:    state_d = (depth_q == '0) ? S_DONE : S_POP;
          CMD_RESET:   state_d = S_DONE;
          default:     state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (k_in_word) begin
          state_d = S_SELECT;
        end else if (last_word) begin
          state_d = S_DONE;
        end
      end
      S_SELECT: begin
        if (lvl_q == 3'd4) state_d = S_DONE;
      end
      S_DISABLE: state_d = S_DONE;
      S_POP:     state_d = S_RESTORE;
      S_RESTORE: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o    = (state_q == S_IDLE);
    res_valid_o  = (state_q == S_DONE);
    mk_clear_o   = 1'b0;
    mk_rd_en_o   = 1'b0;
    mk_rd_addr_o = '0;
    mk_wr_en_o   = 1'b0;
    mk_wr_addr_o = idx_q[BIT_W+WAW-1:BIT_W];
    mk_wr_data_o = mk_rd_data_i & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
    st_wr_en_o   = 1'b0;
    st_wr_addr_o = depth_q[SAW-1:0];
    st_wr_data_o = idx_q;
    st_rd_en_o   = 1'b0;
    st_rd_addr_o = depth_dec[SAW-1:0];
    unique case (state_q)
      S_CHECK: begin
        unique case (cmd_q)
          CMD_DRAW: begin
            mk_rd_en_o = 1'b1;
          end
          CMD_DISABLE: begin
            mk_rd_en_o   = 1'b1;
            mk_rd_addr_o = idx_q[BIT_W+WAW-1:BIT_W];
          end
          CMD_UNDO:  st_rd_en_o = 1'b1;
          CMD_RESET: mk_clear_o = 1'b1;
          default: ;
        endcase
      end
      S_SCAN: begin
        mk_rd_en_o   = 1'b1;
        mk_rd_addr_o = w_q + WAW'(1);
      end
      S_DISABLE: begin
        mk_wr_en_o = dis_bit;
        st_wr_en_o = dis_bit;
      end
      S_POP: begin
        mk_rd_en_o   = 1'b1;
        mk_rd_addr_o = st_rd_data_i[BIT_W+WAW-1:BIT_W];
      end
      S_RESTORE: begin
        mk_wr_en_o   = rst_bit_sel;
        mk_wr_addr_o = e_q[BIT_W+WAW-1:BIT_W];
        mk_wr_data_o = mk_rd_data_i | (WORD_W'(1) << e_q[BIT_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      count_q <= '0;
      nr_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_CHECK: begin
          if (cmd_q == CMD_RESET) begin
            depth_q <= '0;
            count_q <= size;
            nr_q    <= size_zero;
          end
        end
        S_DISABLE: begin
          if (dis_bit) begin
            depth_q <= depth_q + CNT_W'(1);
            count_q <= count_dec;
            if (count_dec == '0) nr_q <= 1'b1;
          end
        end
        S_RESTORE: begin
          depth_q <= depth_dec;
          count_q <= count_inc;
          nr_q    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q  <= cmd_i;
        rank_q <= rank_i;
        idx_q  <= idx_i;
      end
      S_CHECK: begin
        res_q.picked    <= '0;
        res_q.status    <= ST_OK;
        res_q.remaining <= count_q;
        res_q.exhausted <= nr_q;
        k_q             <= rank_q;
        w_q             <= '0;
        unique case (cmd_q)
          CMD_DRAW: begin
            if (size_zero)                     res_q.status <= ST_NOT_LOAD;
            else if (nr_q)                     res_q.status <= ST_EXHAUSTED;
            else if ({1'b0, rank_q} >= count_q) res_q.status <= ST_RANK_BIG;
          end
          CMD_DISABLE: begin
            if (size_zero)    res_q.status <= ST_NOT_LOAD;
            else if (dis_rej) res_q.status <= ST_IGNORED;
          end
          CMD_UNDO: begin
            if (depth_q == '0) res_q.status <= ST_IGNORED;
          end
          CMD_RESET: begin
            res_q.status    <= size_zero ? ST_NOT_LOAD : ST_OK;
            res_q.remaining <= size;
            res_q.exhausted <= size_zero;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (k_in_word) begin
          word_q <= masked;
          base_q <= '0;
          lvl_q  <= '0;
        end else begin
          k_q <= k_q - IDX_W'(pc_word);
          w_q <= w_q + WAW'(1);
          if (last_word) res_q.status <= ST_RANK_BIG;
        end
      end
      S_SELECT: begin
        if (k_in_lo) begin
          word_q <= word_q & lo_mask;
        end else begin
          word_q <= word_q >> half;
          k_q    <= k_q - IDX_W'(pc_lo);
        end
        base_q <= base_next;
        lvl_q  <= lvl_q + 3'd1;
        res_q.picked <= IDX_W'({w_q, base_next});
      end
      S_DISABLE: begin
        if (dis_bit) begin
          res_q.picked    <= idx_q;
          res_q.remaining <= count_dec;
          res_q.exhausted <= (count_dec == '0) ? 1'b1 : nr_q;
        end else begin
          res_q.status <= ST_IGNORED;
        end
      end
      S_POP: begin
        e_q <= st_rd_data_i;
      end
      S_RESTORE: begin
        res_q.picked    <= e_q;
        res_q.remaining <= count_inc;
        res_q.exhausted <= 1'b0;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule
